// ----- rtl/bln_pkg.sv -----
// Package for the bilinear resize and normalize block: payload types,
// register and function codes, reset values and per-channel constant tables.
// No dependencies.
`timescale 1ns / 1ps

package bln_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_SRC_WIDTH_DEF  = 256;
  localparam int MAX_SRC_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF      = 16;

  // Register reset values and target limit.
  localparam int SRC_W_RESET = 256;
  localparam int SRC_H_RESET = 256;
  localparam int TGT_W_RESET = 1024;
  localparam int TGT_H_RESET = 1024;
  localparam int TARGET_MAX  = 2048;

  // Input function codes.
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_TGT_W = 2'd2,
    REG_TGT_H = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic       func;
    logic [10:0] column;
    logic [10:0] line;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] plane0_value;
    logic signed [15:0] plane1_value;
    logic signed [15:0] plane2_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [11:0] data;
  } cfg_item_t;

  // Channel mean times 255, in thousandths (channel = source byte).
  function automatic logic [16:0] chan_mean(input logic [1:0] c);
    logic [16:0] r;
    case (c)
      2'd0:    r = 17'd123675;
      2'd1:    r = 17'd116280;
      2'd2:    r = 17'd103530;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Channel std times 255, in thousandths.
  function automatic logic [15:0] chan_std(input logic [1:0] c);
    logic [15:0] r;
    case (c)
      2'd0:    r = 16'd58395;
      2'd1:    r = 16'd57120;
      2'd2:    r = 16'd57375;
      default: r = 16'd1;
    endcase
    return r;
  endfunction

  // Reciprocal of chan_std, rounded up, scaled by 2^32.
  function automatic logic [16:0] chan_recip(input logic [1:0] c);
    logic [16:0] r;
    case (c)
      2'd0:    r = 17'd73551;
      2'd1:    r = 17'd75193;
      2'd2:    r = 17'd74858;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Dividend limit above which the quotient saturates anyway.
  function automatic logic [30:0] chan_zmax(input logic [1:0] c);
    return 31'(32769 * int'(chan_std(c)));
  endfunction

endpackage

// ----- rtl/bln_if.sv -----
// Valid/ready channel interfaces for the bilinear resize block: input items,
// result items and configuration writes. Depends on bln_pkg.
`timescale 1ns / 1ps

interface bln_in_if;
  logic              valid;
  logic              ready;
  bln_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bln_res_if;
  logic               valid;
  logic               ready;
  bln_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bln_cfg_if;
  logic               valid;
  logic               ready;
  bln_pkg::cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/bln_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bln_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write or read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- rtl/bilinear_resize_normalize_top.sv -----
// Bilinear resize with per-channel normalization over a stored source frame.
// Load item: written to the frame store on the transfer itself.
// Compute item: no new item is taken until its result is loaded (a held result stalls); the
// path runs through four reads of the single-port frame store and a 7-stage channel pipeline.
// Configuration write: the step of the touched axis is recomputed by a serial divider.
// Reset sets control and configuration registers; the frame store is undefined until written.
`timescale 1ns / 1ps

module bilinear_resize_normalize_top #(
  parameter int MAX_SRC_WIDTH  = bln_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = bln_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int FRAC_BITS      = bln_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bln_in_if.sink    in_i,
  bln_cfg_if.sink   cfg_i,
  bln_res_if.source res_o
);

  import bln_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam longint ONE = longint'(1) << F;
  localparam int CRD_W  = 9;
  localparam int STEP_W = CRD_W + F;
  localparam int MUL_W  = F + 21;
  localparam int POS_W  = F + 22;
  localparam int FR_W   = F + 2;
  localparam int H_W    = F + 12;
  localparam int ACC_W  = 2 * F + 15;
  localparam int V_W    = F + 12;
  localparam int W_W    = F + 23;
  localparam int Y_W    = F + 36;
  localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(STEP_W + 1);
  localparam int NST    = 6;

  localparam int RST_SW = (MAX_SRC_WIDTH < SRC_W_RESET) ? MAX_SRC_WIDTH : SRC_W_RESET;
  localparam int RST_SH = (MAX_SRC_HEIGHT < SRC_H_RESET) ? MAX_SRC_HEIGHT : SRC_H_RESET;
  localparam logic [STEP_W-1:0] STEP_X_RST =
    STEP_W'((longint'(RST_SW) << F) / TGT_W_RESET);
  localparam logic [STEP_W-1:0] STEP_Y_RST =
    STEP_W'((longint'(RST_SH) << F) / TGT_H_RESET);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIVLD = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_MAP   = 8'b0000_1000,
    ST_IDX   = 8'b0001_0000,
    ST_RD    = 8'b0010_0000,
    ST_CALC  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [CRD_W-1:0]       i0;
    logic [CRD_W-1:0]       i1;
    logic signed [FR_W-1:0] frac;
  } axis_t;

  // Map a scaled destination position to base, neighbor and fraction.
  function automatic axis_t map_axis(input logic [MUL_W-1:0] prod,
                                     input logic [CRD_W-1:0] src);
    logic signed [POS_W-1:0] p2;
    logic signed [POS_W-1:0] p;
    logic signed [POS_W-1:0] rem;
    logic [POS_W-F-1:0]      bq;
    logic [CRD_W-1:0]        base;
    logic [CRD_W-1:0]        lim;
    axis_t                   r;
    p2  = $signed(POS_W'(prod)) - $signed(POS_W'(ONE));
    p   = p2 >>> 1;
    lim = src - 1'b1;
    bq  = p[POS_W-1:F];
    if (p[POS_W-1]) begin
      base = '0;
    end else if (bq > (POS_W-F)'(lim)) begin
      base = lim;
    end else begin
      base = bq[CRD_W-1:0];
    end
    r.i0 = base;
    r.i1 = (((CRD_W+1)'(base) + 1'b1) < (CRD_W+1)'(src)) ? base + 1'b1 : lim;
    rem    = p - $signed(POS_W'(base) << F);
    r.frac = rem[FR_W-1:0];
    return r;
  endfunction

  // Control state.
  state_e             state_q, state_d;
  logic [CRD_W-1:0]   src_w_q, src_h_q;
  logic [11:0]        tgt_w_q, tgt_h_q;
  logic [STEP_W-1:0]  step_x_q, step_y_q;
  logic               dv_axis_q;
  logic [CNT_W-1:0]   dv_cnt_q;
  logic [2:0]         rd_cnt_q;
  logic [1:0]         feed_q;
  logic [NST-1:0]     st_v_q;
  logic               out_valid_q;

  // Datapath registers.
  logic [STEP_W-1:0]       dv_num_q;
  logic [11:0]             dv_rem_q, dv_den_q;
  logic [10:0]             col_q, row_q;
  logic [MUL_W-1:0]        mx_q, my_q;
  logic [CRD_W-1:0]        x0_q, x1_q, y0_q, y1_q;
  logic signed [FR_W-1:0]  fx_q, fy_q, wx0_q, wy0_q;
  logic [23:0]             pix_q [4];
  logic [1:0]              st_c_q [NST];
  logic signed [H_W-1:0]   h0_q, h1_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [V_W-1:0]   v_q;
  logic signed [W_W-1:0]   w_q;
  logic [30:0]             zc_q, zc6_q;
  logic                    neg_q, neg6_q;
  logic [47:0]             prod_q;
  logic signed [15:0]      res_q [3];
  out_item_t               out_pl_q;

  // Effective register values, clamped to their legal ranges.
  logic [CRD_W-1:0] eff_sw, eff_sh;
  logic [11:0]      eff_tw, eff_th;

  always_comb begin
    eff_sw = (src_w_q == '0) ? CRD_W'(1) :
             ((13'(src_w_q) > 13'(MAX_SRC_WIDTH)) ? CRD_W'(MAX_SRC_WIDTH) : src_w_q);
    eff_sh = (src_h_q == '0) ? CRD_W'(1) :
             ((13'(src_h_q) > 13'(MAX_SRC_HEIGHT)) ? CRD_W'(MAX_SRC_HEIGHT) : src_h_q);
    eff_tw = (tgt_w_q == '0) ? 12'd1 :
             ((tgt_w_q > 12'(TARGET_MAX)) ? 12'(TARGET_MAX) : tgt_w_q);
    eff_th = (tgt_h_q == '0) ? 12'd1 :
             ((tgt_h_q > 12'(TARGET_MAX)) ? 12'(TARGET_MAX) : tgt_h_q);
  end

  // Handshakes: one item or one register write at a time.
  logic in_xfer, cfg_xfer, res_xfer, load_ok;

  assign cfg_i.ready = (state_q == ST_IDLE);
  assign in_i.ready  = (state_q == ST_IDLE) && !cfg_i.valid;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_pl_q;
  assign res_xfer    = out_valid_q && res_o.ready;
  assign load_ok     = (int'(in_i.payload.column) < MAX_SRC_WIDTH) &&
                       (int'(in_i.payload.line) < MAX_SRC_HEIGHT);

  // Frame store port: loads write on transfer, computes read four neighbors.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [23:0]   ram_rdata;
  logic [CRD_W-1:0] rd_x, rd_y;

  always_comb begin
    rd_y = rd_cnt_q[1] ? y1_q : y0_q;
    rd_x = rd_cnt_q[0] ? x1_q : x0_q;
    if (state_q == ST_RD) begin
      ram_we   = 1'b0;
      ram_addr = AW'(AW'(rd_y) * AW'(MAX_SRC_WIDTH)) + AW'(rd_x);
    end else begin
      ram_we   = in_xfer && (in_i.payload.func == FUNC_LOAD) && load_ok;
      ram_addr = AW'(AW'(in_i.payload.line) * AW'(MAX_SRC_WIDTH)) +
                 AW'(in_i.payload.column);
    end
  end

  bln_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({in_i.payload.chan2, in_i.payload.chan1, in_i.payload.chan0}),
    .rdata_o (ram_rdata)
  );

  // Serial restoring divider step for the scale factors.
  logic [12:0] dv_sh;
  logic        dv_ge;

  always_comb begin
    dv_sh = {dv_rem_q, dv_num_q[STEP_W-1]};
    dv_ge = dv_sh >= {1'b0, dv_den_q};
  end

  // Destination clamp and position multiply.
  logic [10:0] dx, dy;

  always_comb begin
    dx = (12'(col_q) > eff_tw - 1'b1) ? 11'(eff_tw - 1'b1) : col_q;
    dy = (12'(row_q) > eff_th - 1'b1) ? 11'(eff_th - 1'b1) : row_q;
  end

  axis_t ax, ay;

  always_comb begin
    ax = map_axis(mx_q, eff_sw);
    ay = map_axis(my_q, eff_sh);
  end

  // Channel pipeline, stage 1: horizontal weighting.
  logic [7:0] b00, b01, b10, b11;
  logic       feed_v;
  logic signed [H_W-1:0] h0_d, h1_d;

  always_comb begin
    feed_v = (state_q == ST_CALC) && (feed_q != 2'd3);
    b00 = pix_q[0][{feed_q, 3'b000} +: 8];
    b01 = pix_q[1][{feed_q, 3'b000} +: 8];
    b10 = pix_q[2][{feed_q, 3'b000} +: 8];
    b11 = pix_q[3][{feed_q, 3'b000} +: 8];
    h0_d = H_W'($signed({1'b0, b00})) * H_W'(wx0_q) +
           H_W'($signed({1'b0, b01})) * H_W'(fx_q);
    h1_d = H_W'($signed({1'b0, b10})) * H_W'(wx0_q) +
           H_W'($signed({1'b0, b11})) * H_W'(fx_q);
  end

  // Stage 2: vertical weighting.
  logic signed [ACC_W-1:0] acc_d;

  assign acc_d = ACC_W'(h0_q) * ACC_W'(wy0_q) + ACC_W'(h1_q) * ACC_W'(fy_q);

  // Stage 3: round back to the fraction scale, half away from zero.
  logic [ACC_W-1:0]      acc_mag, vm;
  logic signed [V_W-1:0] v_d;

  always_comb begin
    acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    vm      = (acc_mag + (ACC_W'(1) << (F - 1))) >> F;
    v_d     = acc_q[ACC_W-1] ? -$signed(V_W'(vm)) : $signed(V_W'(vm));
  end

  // Stage 4: remove the channel mean.
  logic signed [W_W-1:0] w_d;

  assign w_d = W_W'(v_q) * W_W'(1000) - $signed(W_W'(chan_mean(st_c_q[2])) << F);

  // Stage 5: fold the std scaling into one dividend, saturate early.
  logic [W_W-1:0] w_mag;
  logic [Y_W-1:0] y_val, z_val;
  logic [30:0]    zc_d;

  always_comb begin
    w_mag = w_q[W_W-1] ? W_W'(-w_q) : W_W'(w_q);
    y_val = (Y_W'(w_mag) << 13) + (Y_W'(chan_std(st_c_q[3])) << F);
    z_val = y_val >> (F + 1);
    zc_d  = (z_val > Y_W'(chan_zmax(st_c_q[3]))) ? chan_zmax(st_c_q[3]) : 31'(z_val);
  end

  // Stage 7: correct the reciprocal quotient, apply sign and saturate.
  logic [15:0]        qe, q;
  logic [31:0]        chk;
  logic signed [16:0] qs;
  logic signed [15:0] res_d;

  always_comb begin
    qe  = prod_q[47:32];
    chk = 32'(qe) * 32'(chan_std(st_c_q[5]));
    q   = (chk > 32'(zc6_q)) ? qe - 1'b1 : qe;
    qs  = neg6_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (qs > 17'sd32767) begin
      res_d = 16'sh7fff;
    end else if (qs < -17'sd32768) begin
      res_d = -16'sd32768;
    end else begin
      res_d = qs[15:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_xfer) begin
          state_d = ST_DIVLD;
        end else if (in_xfer && (in_i.payload.func == FUNC_COMPUTE)) begin
          state_d = ST_MAP;
        end
      end
      ST_DIVLD: state_d = ST_DIV;
      ST_DIV: begin
        if (dv_cnt_q == CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_MAP: state_d = ST_IDX;
      ST_IDX: state_d = ST_RD;
      ST_RD: begin
        if (rd_cnt_q == 3'd4) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (st_v_q[NST-1] && (st_c_q[NST-1] == 2'd2)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_w_q     <= CRD_W'(SRC_W_RESET);
      src_h_q     <= CRD_W'(SRC_H_RESET);
      tgt_w_q     <= 12'(TGT_W_RESET);
      tgt_h_q     <= 12'(TGT_H_RESET);
      step_x_q    <= STEP_X_RST;
      step_y_q    <= STEP_Y_RST;
      dv_axis_q   <= 1'b0;
      dv_cnt_q    <= '0;
      rd_cnt_q    <= '0;
      feed_q      <= '0;
      st_v_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Register write, then recompute the step of the axis it touches.
      if (cfg_xfer) begin
        dv_axis_q <= cfg_i.payload.index[0];
        case (cfg_i.payload.index)
          REG_SRC_W: src_w_q <= cfg_i.payload.data[CRD_W-1:0];
          REG_SRC_H: src_h_q <= cfg_i.payload.data[CRD_W-1:0];
          REG_TGT_W: tgt_w_q <= cfg_i.payload.data;
          REG_TGT_H: tgt_h_q <= cfg_i.payload.data;
          default:   src_w_q <= src_w_q;
        endcase
      end
      if (state_q == ST_DIVLD) begin
        dv_cnt_q <= CNT_W'(STEP_W);
      end else if (state_q == ST_DIV) begin
        dv_cnt_q <= dv_cnt_q - 1'b1;
        if (dv_cnt_q == CNT_W'(1)) begin
          if (dv_axis_q) begin
            step_y_q <= {dv_num_q[STEP_W-2:0], dv_ge};
          end else begin
            step_x_q <= {dv_num_q[STEP_W-2:0], dv_ge};
          end
        end
      end

      // Read sequencer over the four neighbors.
      if (state_q == ST_RD) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end else begin
        rd_cnt_q <= '0;
      end

      // Channel feed and pipeline valid bits.
      if (feed_v) begin
        feed_q <= feed_q + 1'b1;
      end else if (state_q != ST_CALC) begin
        feed_q <= '0;
      end
      st_v_q <= {st_v_q[NST-2:0], feed_v};

      // Output register: loaded when the result is complete.
      if ((state_q == ST_DONE) && (!out_valid_q || res_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (res_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    // Divider operands and iteration.
    if (state_q == ST_DIVLD) begin
      dv_num_q <= dv_axis_q ? (STEP_W'(eff_sh) << F) : (STEP_W'(eff_sw) << F);
      dv_den_q <= dv_axis_q ? eff_th : eff_tw;
      dv_rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      dv_num_q <= {dv_num_q[STEP_W-2:0], dv_ge};
      dv_rem_q <= dv_ge ? 12'(dv_sh - {1'b0, dv_den_q}) : dv_sh[11:0];
    end

    if (in_xfer) begin
      col_q <= in_i.payload.column;
      row_q <= in_i.payload.line;
    end

    if (state_q == ST_MAP) begin
      mx_q <= MUL_W'({dx, 1'b1}) * MUL_W'(step_x_q);
      my_q <= MUL_W'({dy, 1'b1}) * MUL_W'(step_y_q);
    end

    if (state_q == ST_IDX) begin
      x0_q  <= ax.i0;
      x1_q  <= ax.i1;
      fx_q  <= ax.frac;
      wx0_q <= $signed(FR_W'(ONE)) - ax.frac;
      y0_q  <= ay.i0;
      y1_q  <= ay.i1;
      fy_q  <= ay.frac;
      wy0_q <= $signed(FR_W'(ONE)) - ay.frac;
    end

    // Read data is registered: it arrives in the cycle after each address.
    if ((state_q == ST_RD) && (rd_cnt_q != 3'd0)) begin
      pix_q[2'(rd_cnt_q - 3'd1)] <= ram_rdata;
    end

    // Channel pipeline.
    st_c_q[0] <= feed_q;
    for (int i = 1; i < NST; i++) begin
      st_c_q[i] <= st_c_q[i-1];
    end
    h0_q   <= h0_d;
    h1_q   <= h1_d;
    acc_q  <= acc_d;
    v_q    <= v_d;
    w_q    <= w_d;
    zc_q   <= zc_d;
    neg_q  <= w_q[W_W-1];
    prod_q <= 48'(zc_q) * 48'(chan_recip(st_c_q[4]));
    zc6_q  <= zc_q;
    neg6_q <= neg_q;
    if (st_v_q[NST-1]) begin
      res_q[2'(2'd2 - st_c_q[NST-1])] <= res_d;
    end

    if ((state_q == ST_DONE) && (!out_valid_q || res_o.ready)) begin
      out_pl_q.plane0_value <= res_q[0];
      out_pl_q.plane1_value <= res_q[1];
      out_pl_q.plane2_value <= res_q[2];
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for bilinear_resize_normalize_top: loads source
// frames, requests resampled pixels and checks them against an in-bench
// fixed-point predictor. Depends on bln_pkg and the interfaces in bln_if.sv.
`timescale 1ns / 1ps

module tb;
  import bln_pkg::*;

  logic clk_i;
  logic rst_ni;

  bln_in_if  in_if ();
  bln_cfg_if cfg_if ();
  bln_res_if res_if ();

  bilinear_resize_normalize_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .cfg_i (cfg_if.sink),
    .res_o (res_if.source)
  );

  // Mirror of the block state.
  logic [23:0] pixel_mem [int];
  longint      src_w, src_h, tgt_w, tgt_h, stride_x, stride_y;

  in_item_t    pending_items [$];
  out_item_t   expected_pixels [$];
  int          idle_pct, stall_pct;
  int          errors, pixels_seen, loads_sent;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic longint clampv(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void refresh_strides();
    stride_x = (clampv(src_w, 1, 256) << 16) / clampv(tgt_w, 1, TARGET_MAX);
    stride_y = (clampv(src_h, 1, 256) << 16) / clampv(tgt_h, 1, TARGET_MAX);
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // Maps one destination coordinate to base, neighbor and signed fraction.
  task automatic map_coord(input longint d, input longint stride, input longint src,
                           output longint i0, output longint i1, output longint fr);
    longint p2, p, base;
    p2 = (2 * d + 1) * stride - 65536;
    p = (p2 >= 0) ? (p2 / 2) : -((-p2 + 1) / 2);
    base = (p >= 0) ? (p / 65536) : -1;
    base = clampv(base, 0, src - 1);
    i0 = base;
    i1 = (base + 1 < src) ? base + 1 : src - 1;
    fr = p - base * 65536;
  endtask

  // Predicts the three normalized planes of one destination pixel.
  task automatic resample_pixel(input longint col, input longint row,
                                output out_item_t res);
    longint sw, sh, x0, x1, y0, y1, fx, fy, h0, h1, acc, v, r;
    logic [23:0] p00, p01, p10, p11;
    longint means [3];
    longint stds [3];
    means = '{485, 456, 406};
    stds = '{229, 224, 225};
    sw = clampv(src_w, 1, 256);
    sh = clampv(src_h, 1, 256);
    col = (col > clampv(tgt_w, 1, TARGET_MAX) - 1) ? clampv(tgt_w, 1, TARGET_MAX) - 1 : col;
    row = (row > clampv(tgt_h, 1, TARGET_MAX) - 1) ? clampv(tgt_h, 1, TARGET_MAX) - 1 : row;
    map_coord(col, stride_x, sw, x0, x1, fx);
    map_coord(row, stride_y, sh, y0, y1, fy);
    p00 = pixel_mem[int'(y0 * 256 + x0)];
    p01 = pixel_mem[int'(y0 * 256 + x1)];
    p10 = pixel_mem[int'(y1 * 256 + x0)];
    p11 = pixel_mem[int'(y1 * 256 + x1)];
    for (int c = 0; c < 3; c++) begin
      h0 = longint'(p00[8*c +: 8]) * (65536 - fx) + longint'(p01[8*c +: 8]) * fx;
      h1 = longint'(p10[8*c +: 8]) * (65536 - fx) + longint'(p11[8*c +: 8]) * fx;
      acc = h0 * (65536 - fy) + h1 * fy;
      v = round_div(acc, 65536);
      r = round_div((v * 1000 - means[c] * 255 * 65536) * 4096, stds[c] * 255 * 65536);
      r = clampv(r, -32768, 32767);
      case (c)
        0: res.plane2_value = 16'(r);
        1: res.plane1_value = 16'(r);
        default: res.plane0_value = 16'(r);
      endcase
    end
  endtask

  // Input driver: presents queued items, updates the mirror on each transfer.
  always @(posedge clk_i) begin
    out_item_t pred;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        if (in_if.payload.func == FUNC_LOAD) begin
          if (in_if.payload.column < 256 && in_if.payload.line < 256)
            pixel_mem[int'(in_if.payload.line) * 256 + int'(in_if.payload.column)] =
              {in_if.payload.chan2, in_if.payload.chan1, in_if.payload.chan0};
        end else begin
          resample_pixel(in_if.payload.column, in_if.payload.line, pred);
          expected_pixels.push_back(pred);
        end
      end
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_if.payload <= pending_items.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side: random backpressure and field-by-field comparison.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: expected no result, actual %h", $time, res_if.payload);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          pixels_seen++;
          if (res_if.payload.plane0_value !== want.plane0_value) begin
            $display("%0t: plane0 expected %0d actual %0d", $time,
                     want.plane0_value, res_if.payload.plane0_value);
            errors++;
          end
          if (res_if.payload.plane1_value !== want.plane1_value) begin
            $display("%0t: plane1 expected %0d actual %0d", $time,
                     want.plane1_value, res_if.payload.plane1_value);
            errors++;
          end
          if (res_if.payload.plane2_value !== want.plane2_value) begin
            $display("%0t: plane2 expected %0d actual %0d", $time,
                     want.plane2_value, res_if.payload.plane2_value);
            errors++;
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic reg_write(input cfg_reg_e idx, input logic [11:0] data);
    @(posedge clk_i);
    cfg_if.payload <= '{index: idx, data: data};
    cfg_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_SRC_W: src_w = data & 12'h1FF;
      REG_SRC_H: src_h = data & 12'h1FF;
      REG_TGT_W: tgt_w = data;
      default:   tgt_h = data;
    endcase
    refresh_strides();
  endtask

  task automatic add_item(input logic fn, input int col, input int row,
                          input logic [23:0] px);
    in_item_t it;
    it.func = fn;
    it.column = 11'(col);
    it.line = 11'(row);
    {it.chan2, it.chan1, it.chan0} = px;
    pending_items.push_back(it);
    if (fn == FUNC_LOAD) loads_sent++;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_if.valid || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Writes every pixel of the active source region.
  task automatic fill_frame();
    for (int y = 0; y < clampv(src_h, 1, 256); y++)
      for (int x = 0; x < clampv(src_w, 1, 256); x++)
        add_item(FUNC_LOAD, x, y, 24'($urandom));
  endtask

  initial begin
    int tw, th, sw, sh, col, row;
    logic [11:0] cfgs [6][4];
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    res_if.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    pixels_seen = 0;
    loads_sent = 0;
    src_w = SRC_W_RESET;
    src_h = SRC_H_RESET;
    tgt_w = TGT_W_RESET;
    tgt_h = TGT_H_RESET;
    refresh_strides();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Settings: upscale, widest target, overlarge and zero values that clamp
    // (giving the widest source), downscale, single pixel, an uneven upscale, then random ones.
    cfgs = '{'{12'd4, 12'd3, 12'd7, 12'd5},
             '{12'd3, 12'd2, 12'd2048, 12'd1},
             '{12'h1FF, 12'hE00, 12'd0, 12'hFFF},
             '{12'd9, 12'd7, 12'd3, 12'd2},
             '{12'd1, 12'd1, 12'd1, 12'd1},
             '{12'd5, 12'd6, 12'd13, 12'd11}};

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) begin
        reg_write(REG_SRC_W, cfgs[ph][0]);
        reg_write(REG_SRC_H, cfgs[ph][1]);
        reg_write(REG_TGT_W, cfgs[ph][2]);
        reg_write(REG_TGT_H, cfgs[ph][3]);
      end else begin
        reg_write(REG_SRC_W, 12'($urandom_range(12, 1)));
        reg_write(REG_SRC_H, 12'($urandom_range(12, 1)));
        reg_write(REG_TGT_W, 12'($urandom_range(40, 1)));
        reg_write(REG_TGT_H, 12'($urandom_range(40, 1)));
      end
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 86; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 86; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      sw = int'(clampv(src_w, 1, 256));
      sh = int'(clampv(src_h, 1, 256));
      tw = int'(clampv(tgt_w, 1, TARGET_MAX));
      th = int'(clampv(tgt_h, 1, TARGET_MAX));
      fill_frame();

      // Directed corners, extreme bytes and ignored or saturated coordinates.
      if (ph == 0) begin
        add_item(FUNC_LOAD, 0, 0, 24'hFFFFFF);
        add_item(FUNC_LOAD, sw - 1, sh - 1, 24'h000000);
        add_item(FUNC_LOAD, 2047, 2047, 24'h123456);
        add_item(FUNC_LOAD, 256, 0, 24'hABCDEF);
        add_item(FUNC_LOAD, 0, 256, 24'h00FF00);
        add_item(FUNC_COMPUTE, 0, 0, 24'hFFFFFF);
        add_item(FUNC_COMPUTE, tw - 1, th - 1, 24'h0);
        add_item(FUNC_COMPUTE, tw - 1, 0, 24'h0);
        add_item(FUNC_COMPUTE, 0, th - 1, 24'h0);
        add_item(FUNC_COMPUTE, 2047, 2047, 24'h0);
        add_item(FUNC_COMPUTE, tw, th, 24'h0);
        add_item(FUNC_COMPUTE, 1, 1, 24'h0);
      end

      // Random mix of computes and loads, mostly inside the active ranges.
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(99) < 70) begin
          if ($urandom_range(9) == 0) begin
            col = $urandom_range(2047);
            row = $urandom_range(2047);
          end else begin
            col = $urandom_range(tw + 1);
            row = $urandom_range(th + 1);
          end
          add_item(FUNC_COMPUTE, col, row, 24'($urandom));
        end else if ($urandom_range(9) == 0) begin
          add_item(FUNC_LOAD, $urandom_range(2047, 256), $urandom_range(2047), 24'($urandom));
        end else begin
          add_item(FUNC_LOAD, $urandom_range(sw - 1), $urandom_range(sh - 1),
                   24'($urandom));
        end
      end
      drain();
    end

    $display("tb: %0d pixels checked, %0d loads, 8 register settings, 4 flow modes",
             pixels_seen, loads_sent);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("tb: timeout");
    $display("tb: FAIL");
    $finish;
  end

endmodule
